/* src/spdc_pkg.sv */
package spdc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND = 2'd3;

  localparam logic [15:0] GAIN_P_RST    = 16'd256;
  localparam logic [15:0] GAIN_I_RST    = 16'd0;
  localparam logic [15:0] GAIN_D_RST    = 16'd0;
  localparam logic [9:0]  DEAD_BAND_RST = 10'd10;

  // Drive modes
  localparam logic [7:0] MODE_PAUSE  = 8'd0;
  localparam logic [7:0] MODE_MANUAL = 8'd1;
  localparam logic [7:0] MODE_AUTO   = 8'd2;

  // Status codes
  localparam logic [3:0] ST_N     = 4'd0;
  localparam logic [3:0] ST_R     = 4'd1;
  localparam logic [3:0] ST_L     = 4'd2;
  localparam logic [3:0] ST_PAUSE = 4'd3;
  localparam logic [3:0] ST_AN    = 4'd4;
  localparam logic [3:0] ST_AR    = 4'd5;
  localparam logic [3:0] ST_AL    = 4'd6;
  localparam logic [3:0] ST_HOLD  = 4'd7;
  localparam logic [3:0] ST_ERROR = 4'd8;
  localparam logic [3:0] ST_NOSIG = 4'd9;

  // Bridge sides
  localparam logic [1:0] SIDE_OFF   = 2'd0;
  localparam logic [1:0] SIDE_RIGHT = 2'd1;
  localparam logic [1:0] SIDE_LEFT  = 2'd2;

  // Arithmetic constants
  localparam logic signed [17:0] INTEG_MAX = 18'sd100000;
  localparam logic signed [17:0] INTEG_MIN = -18'sd100000;
  localparam logic signed [16:0] D_SCALE   = 17'sd1000;
  localparam logic [7:0]         DUTY_MAX  = 8'd255;
  localparam logic signed [11:0] ERR_MIN   = -12'sd2048;
  localparam logic signed [9:0]  REP_MIN   = -10'sd512;
  localparam logic signed [9:0]  REP_MAX   = 10'sd511;

  // Divide by 1000 for a dividend below 2^33: ((x >> 3) * 0x4189374C) >> 37
  localparam logic [15:0] RCP_M_HI = 16'h4189;
  localparam logic [15:0] RCP_M_LO = 16'h374C;

  // Divider geometry
  localparam int DIV_W     = 40;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_CNT_INIT = DIV_CNT_W'(DIV_W);

  // Microcode
  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    OP_ERR,
    OP_MUL_EDT,
    OP_INTEG,
    OP_MUL_P,
    OP_MUL_I,
    OP_RCP_LD,
    OP_RCP_HI,
    OP_RCP_LO,
    OP_DIV_STEP,
    OP_ADD_Q,
    OP_MUL_D1,
    OP_MUL_D2,
    OP_DIV_LD_D,
    OP_FINISH
  } op_t;

  typedef enum logic [1:0] {
    CND_NONE,
    CND_NO_PID,
    CND_DIV_MORE,
    CND_DT_ZERO
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  localparam logic [PC_W-1:0] PC_START  = 4'd0;
  localparam logic [PC_W-1:0] PC_DIV_D  = 4'd12;
  localparam logic [PC_W-1:0] PC_FINISH = 4'd14;

  // Control program for one tick
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      4'd0:    w = '{OP_ERR,      CND_NO_PID,   PC_FINISH};
      4'd1:    w = '{OP_MUL_EDT,  CND_NONE,     PC_START};
      4'd2:    w = '{OP_INTEG,    CND_NONE,     PC_START};
      4'd3:    w = '{OP_MUL_P,    CND_NONE,     PC_START};
      4'd4:    w = '{OP_MUL_I,    CND_NONE,     PC_START};
      4'd5:    w = '{OP_RCP_LD,   CND_NONE,     PC_START};
      4'd6:    w = '{OP_RCP_HI,   CND_NONE,     PC_START};
      4'd7:    w = '{OP_RCP_LO,   CND_NONE,     PC_START};
      4'd8:    w = '{OP_ADD_Q,    CND_DT_ZERO,  PC_FINISH};
      4'd9:    w = '{OP_MUL_D1,   CND_NONE,     PC_START};
      4'd10:   w = '{OP_MUL_D2,   CND_NONE,     PC_START};
      4'd11:   w = '{OP_DIV_LD_D, CND_NONE,     PC_START};
      4'd12:   w = '{OP_DIV_STEP, CND_DIV_MORE, PC_DIV_D};
      4'd13:   w = '{OP_ADD_Q,    CND_NONE,     PC_START};
      default: w = '{OP_FINISH,   CND_NONE,     PC_START};
    endcase
    return w;
  endfunction

endpackage

/* src/steering_pid_drive_control.sv */
// Channel  Direction  Handshake          Payload
// in_      in         in_valid/in_stall   pot, link, mode, two targets, fresh, now_ms
// out_     out        out_valid/out_stall duty, side, status, pot echo, error report
// cfg_     in         cfg_valid/cfg_ready register index, 16-bit write data
//
// One tick at a time, run by a 15-step control program over one shared 33x17
// multiplier and one restoring divider that retires one quotient bit a cycle;
// the divide by 1000 is a two-step reciprocal multiplication on the multiplier.
// A tick with no PID jumps from the first step to the finish step; a zero
// time step skips the derivative and its 40-step division by the time step.
// Reset is synchronous, active low; gains, dead band, integral, last error and
// last time return to their reset values. in_stall is high while a tick runs;
// a stalled result holds the last program step until the output slot frees.
module steering_pid_drive_control (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [9:0]                     in_pot_reading,
  input  logic                           in_link_good,
  input  logic [7:0]                     in_drive_mode,
  input  logic signed [11:0]             in_manual_target,
  input  logic signed [11:0]             in_auto_target,
  input  logic                           in_command_fresh,
  input  logic [31:0]                    in_now_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_pwm_duty,
  output logic [1:0]                     out_drive_side,
  output logic [3:0]                     out_status_code,
  output logic [9:0]                     out_pot_echo,
  output logic signed [9:0]              out_error_report,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [spdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import spdc_pkg::*;

  // Sequencer and handshake state
  logic                 busy_r, busy_nxt;
  logic [PC_W-1:0]      pc_r, pc_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Configuration
  logic [15:0]          gain_p_r, gain_p_nxt;
  logic [15:0]          gain_i_r, gain_i_nxt;
  logic [15:0]          gain_d_r, gain_d_nxt;
  logic [9:0]           dead_band_r, dead_band_nxt;

  // Controller state
  logic signed [17:0]   isum_r, isum_nxt;
  logic signed [11:0]   prev_err_r, prev_err_nxt;
  logic [31:0]          prev_time_r, prev_time_nxt;

  // Captured tick
  logic [9:0]           pot_r, pot_nxt;
  logic signed [11:0]   target_r, target_nxt;
  logic [31:0]          now_r, now_nxt;
  logic                 run_pid_r, run_pid_nxt;
  logic                 auto_r, auto_nxt;
  logic [3:0]           status_r, status_nxt;

  // Datapath
  logic signed [11:0]   e_r, e_nxt;
  logic [31:0]          dt_r, dt_nxt;
  logic signed [45:0]   prod_r, prod_nxt;
  logic signed [17:0]   integ_r, integ_nxt;
  logic signed [41:0]   sum_r, sum_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [31:0]          divisor_r, divisor_nxt;
  logic                 div_neg_r, div_neg_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  // Result register
  logic [7:0]           duty_r, duty_nxt;
  logic [1:0]           side_r, side_nxt;
  logic [3:0]           ostat_r, ostat_nxt;
  logic [9:0]           echo_r, echo_nxt;
  logic signed [9:0]    rep_r, rep_nxt;

  // Combinational helpers
  uword_t               uw;
  logic                 in_xfer;
  logic                 out_free;
  logic                 jump;
  logic signed [32:0]   mul_a;
  logic signed [16:0]   mul_b;
  logic signed [49:0]   mul_p;
  logic signed [13:0]   err_raw;
  logic signed [12:0]   diff;
  logic signed [46:0]   integ_raw;
  logic [45:0]          prod_mag;
  logic [61:0]          rcp_full;
  logic [32:0]          rem_shift;
  logic                 q_bit;
  logic [41:0]          q_ext;
  logic [41:0]          sum_mag;
  logic [33:0]          duty_full;
  logic signed [12:0]   e_ext;
  logic [12:0]          abs_e;
  logic signed [11:0]   err_out;

  assign in_stall  = busy_r;
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid & ~busy_r;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign uw        = ucode_rom(pc_r);

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (uw.op)
      OP_MUL_EDT: begin
        mul_a = $signed({1'b0, dt_r});
        mul_b = 17'(e_r);
      end
      OP_MUL_P: begin
        mul_a = $signed({17'd0, gain_p_r});
        mul_b = 17'(e_r);
      end
      OP_MUL_I: begin
        mul_a = 33'(integ_r);
        mul_b = $signed({1'b0, gain_i_r});
      end
      OP_RCP_HI: begin
        mul_a = $signed({3'd0, quo_r[29:0]});
        mul_b = $signed({1'b0, RCP_M_HI});
      end
      OP_RCP_LO: begin
        mul_a = $signed({3'd0, quo_r[29:0]});
        mul_b = $signed({1'b0, RCP_M_LO});
      end
      OP_MUL_D1: begin
        mul_a = $signed({17'd0, gain_d_r});
        mul_b = 17'(diff);
      end
      OP_MUL_D2: begin
        mul_a = prod_r[32:0];
        mul_b = D_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign err_raw   = 14'(target_r) - $signed({4'd0, pot_r});
  assign diff      = 13'(e_r) - 13'(prev_err_r);
  assign integ_raw = 47'(isum_r) + 47'(prod_r);
  assign prod_mag  = prod_r[45] ? 46'(-prod_r) : 46'(prod_r);
  // Full reciprocal product: high partial product from the last step plus the low one
  assign rcp_full  = {prod_r[45:0], 16'd0} + {16'd0, mul_p[45:0]};
  assign rem_shift = {rem_r, quo_r[DIV_W-1]};
  assign q_bit     = rem_shift >= {1'b0, divisor_r};
  assign q_ext     = {2'b00, quo_r};
  assign sum_mag   = sum_r[41] ? 42'(-sum_r) : 42'(sum_r);
  assign duty_full = sum_mag[41:8];
  assign e_ext     = 13'(e_r);
  assign abs_e     = e_ext[12] ? 13'(-e_ext) : 13'(e_ext);
  assign err_out   = run_pid_r ? e_r : prev_err_r;

  // Branch condition of the current step
  always_comb begin
    unique case (uw.cond)
      CND_NO_PID:   jump = ~run_pid_r;
      CND_DIV_MORE: jump = div_cnt_r != DIV_CNT_W'(1);
      CND_DT_ZERO:  jump = dt_r == '0;
      default:      jump = 1'b0;
    endcase
  end

  // Next-state logic
  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r;
    gain_p_nxt    = gain_p_r;
    gain_i_nxt    = gain_i_r;
    gain_d_nxt    = gain_d_r;
    dead_band_nxt = dead_band_r;
    isum_nxt      = isum_r;
    prev_err_nxt  = prev_err_r;
    prev_time_nxt = prev_time_r;
    pot_nxt       = pot_r;
    target_nxt    = target_r;
    now_nxt       = now_r;
    run_pid_nxt   = run_pid_r;
    auto_nxt      = auto_r;
    status_nxt    = status_r;
    e_nxt         = e_r;
    dt_nxt        = dt_r;
    prod_nxt      = prod_r;
    integ_nxt     = integ_r;
    sum_nxt       = sum_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    divisor_nxt   = divisor_r;
    div_neg_nxt   = div_neg_r;
    div_cnt_nxt   = div_cnt_r;
    duty_nxt      = duty_r;
    side_nxt      = side_r;
    ostat_nxt     = ostat_r;
    echo_nxt      = echo_r;
    rep_nxt       = rep_r;

    // Write configuration
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GAIN_P:    gain_p_nxt    = cfg_data;
        CFG_GAIN_I:    gain_i_nxt    = cfg_data;
        CFG_GAIN_D:    gain_d_nxt    = cfg_data;
        CFG_DEAD_BAND: dead_band_nxt = cfg_data[9:0];
        default:       gain_p_nxt    = gain_p_r;
      endcase
    end

    // Drop a result once its transfer completes
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Capture a tick and decide the mode
    if (in_xfer) begin
      busy_nxt    = 1'b1;
      pc_nxt      = PC_START;
      pot_nxt     = in_pot_reading;
      now_nxt     = in_now_ms;
      run_pid_nxt = 1'b0;
      auto_nxt    = 1'b0;
      target_nxt  = in_manual_target;
      priority if (!in_link_good) begin
        status_nxt = ST_NOSIG;
      end else if (in_drive_mode == MODE_PAUSE) begin
        status_nxt = ST_PAUSE;
      end else if (in_drive_mode == MODE_MANUAL) begin
        status_nxt  = ST_N;
        run_pid_nxt = 1'b1;
      end else if (in_drive_mode == MODE_AUTO) begin
        target_nxt = in_auto_target;
        if (in_command_fresh) begin
          status_nxt  = ST_AN;
          run_pid_nxt = 1'b1;
          auto_nxt    = 1'b1;
        end else begin
          status_nxt = ST_HOLD;
        end
      end else begin
        status_nxt = ST_ERROR;
      end
    end

    // Execute one control word
    if (busy_r) begin
      if (uw.op != OP_FINISH) begin
        pc_nxt = jump ? uw.target : pc_r + PC_W'(1);
      end
      unique case (uw.op)
        OP_ERR: begin
          e_nxt  = (err_raw < 14'(ERR_MIN)) ? ERR_MIN : err_raw[11:0];
          dt_nxt = now_r - prev_time_r;
        end
        OP_MUL_EDT, OP_MUL_I, OP_MUL_D1, OP_MUL_D2, OP_RCP_HI: begin
          prod_nxt = mul_p[45:0];
        end
        OP_INTEG: begin
          priority if (integ_raw > 47'(INTEG_MAX)) begin
            integ_nxt = INTEG_MAX;
          end else if (integ_raw < 47'(INTEG_MIN)) begin
            integ_nxt = INTEG_MIN;
          end else begin
            integ_nxt = integ_raw[17:0];
          end
        end
        OP_MUL_P: begin
          sum_nxt = mul_p[41:0];
        end
        OP_RCP_LD: begin
          // Keep the sign and hold the magnitude divided by 8
          div_neg_nxt = prod_r[45];
          quo_nxt     = DIV_W'(prod_mag[32:3]);
        end
        OP_RCP_LO: begin
          quo_nxt = DIV_W'(rcp_full[61:37]);
        end
        OP_DIV_LD_D: begin
          div_neg_nxt = prod_r[45];
          quo_nxt     = prod_mag[DIV_W-1:0];
          rem_nxt     = '0;
          divisor_nxt = dt_r;
          div_cnt_nxt = DIV_CNT_INIT;
        end
        OP_DIV_STEP: begin
          rem_nxt     = q_bit ? 32'(rem_shift - {1'b0, divisor_r}) : rem_shift[31:0];
          quo_nxt     = {quo_r[DIV_W-2:0], q_bit};
          div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
        end
        OP_ADD_Q: begin
          sum_nxt = div_neg_r ? 42'(sum_r - $signed(q_ext)) : 42'(sum_r + $signed(q_ext));
        end
        OP_FINISH: begin
          // Hold until the output slot frees, then commit state and load result
          if (out_free) begin
            busy_nxt      = 1'b0;
            pc_nxt        = PC_START;
            out_valid_nxt = 1'b1;
            echo_nxt      = pot_r;
            duty_nxt      = '0;
            side_nxt      = SIDE_OFF;
            ostat_nxt     = status_r;
            if (run_pid_r) begin
              prev_time_nxt = now_r;
              prev_err_nxt  = e_r;
              isum_nxt      = integ_r;
              if (abs_e <= {3'd0, dead_band_r}) begin
                ostat_nxt = auto_r ? ST_AN : ST_N;
              end else begin
                duty_nxt = (duty_full[33:8] != '0) ? DUTY_MAX : duty_full[7:0];
                if (!sum_r[41] && sum_r != '0) begin
                  side_nxt  = SIDE_RIGHT;
                  ostat_nxt = auto_r ? ST_AR : ST_R;
                end else begin
                  side_nxt  = SIDE_LEFT;
                  ostat_nxt = auto_r ? ST_AL : ST_L;
                end
              end
            end
            priority if (err_out < 12'(REP_MIN)) begin
              rep_nxt = REP_MIN;
            end else if (err_out > 12'(REP_MAX)) begin
              rep_nxt = REP_MAX;
            end else begin
              rep_nxt = err_out[9:0];
            end
          end
        end
        default: begin
          pc_nxt = PC_FINISH;
        end
      endcase
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= PC_START;
      out_valid_r <= 1'b0;
      gain_p_r    <= GAIN_P_RST;
      gain_i_r    <= GAIN_I_RST;
      gain_d_r    <= GAIN_D_RST;
      dead_band_r <= DEAD_BAND_RST;
      isum_r      <= '0;
      prev_err_r  <= '0;
      prev_time_r <= '0;
      div_cnt_r   <= '0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      gain_p_r    <= gain_p_nxt;
      gain_i_r    <= gain_i_nxt;
      gain_d_r    <= gain_d_nxt;
      dead_band_r <= dead_band_nxt;
      isum_r      <= isum_nxt;
      prev_err_r  <= prev_err_nxt;
      prev_time_r <= prev_time_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
    pot_r     <= pot_nxt;
    target_r  <= target_nxt;
    now_r     <= now_nxt;
    run_pid_r <= run_pid_nxt;
    auto_r    <= auto_nxt;
    status_r  <= status_nxt;
    e_r       <= e_nxt;
    dt_r      <= dt_nxt;
    prod_r    <= prod_nxt;
    integ_r   <= integ_nxt;
    sum_r     <= sum_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
    div_neg_r <= div_neg_nxt;
    duty_r    <= duty_nxt;
    side_r    <= side_nxt;
    ostat_r   <= ostat_nxt;
    echo_r    <= echo_nxt;
    rep_r     <= rep_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pwm_duty     = duty_r;
  assign out_drive_side   = side_r;
  assign out_status_code  = ostat_r;
  assign out_pot_echo     = echo_r;
  assign out_error_report = rep_r;

  // A new result only appears from the last program step
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r && pc_r == PC_FINISH))
    else $error("result loaded outside the finish step");

  // Integral stays inside its clamp
  a_integ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (isum_r <= INTEG_MAX) && (isum_r >= INTEG_MIN))
    else $error("integral out of range");

  // A transferred tick starts the program at its first step
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> busy_r && pc_r == PC_START)
    else $error("tick not started after transfer");

  // A driven side goes with a driving status
  a_side_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && side_r != SIDE_OFF) |->
      (ostat_r == ST_R || ostat_r == ST_L || ostat_r == ST_AR || ostat_r == ST_AL))
    else $error("side driven with a stop status");

  // The divider only counts during a running tick
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (div_cnt_r != '0) |-> busy_r)
    else $error("divider active while idle");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import spdc_pkg::*;

  localparam int     QUIET_LIMIT   = 2000;
  localparam int     SETTLE_CYCLES = 120;
  localparam int     RAND_PHASES   = 7;
  localparam int     PHASE_TICKS   = 270;
  localparam longint INTEG_LIM     = 100000;
  localparam longint MS_PER_S      = 1000;
  localparam longint Q8_ONE        = 256;
  localparam longint ERR_LO        = -2048;
  localparam longint ERR_HI        = 2047;
  localparam longint REP_LO        = -512;
  localparam longint REP_HI        = 511;

  // Modes with no meaning to the block
  localparam logic [7:0] MODE_UNKNOWN_LO = 8'd3;
  localparam logic [7:0] MODE_UNKNOWN_HI = 8'hFF;

  typedef struct {
    logic [9:0]         pot;
    logic               link;
    logic [7:0]         mode;
    logic signed [11:0] man_tgt;
    logic signed [11:0] auto_tgt;
    logic               fresh;
    logic [31:0]        now_ms;
  } tick_t;

  typedef struct {
    logic [7:0]        duty;
    logic [1:0]        side;
    logic [3:0]        status;
    logic [9:0]        pot_echo;
    logic signed [9:0] err_rep;
  } drive_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [9:0]            in_pot_reading = '0;
  logic                  in_link_good = 1'b0;
  logic [7:0]            in_drive_mode = '0;
  logic signed [11:0]    in_manual_target = '0;
  logic signed [11:0]    in_auto_target = '0;
  logic                  in_command_fresh = 1'b0;
  logic [31:0]           in_now_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_pwm_duty;
  logic [1:0]            out_drive_side;
  logic [3:0]            out_status_code;
  logic [9:0]            out_pot_echo;
  logic signed [9:0]     out_error_report;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [15:0]           cfg_data = '0;

  // Expected controller settings and loop state
  logic [15:0] kp = GAIN_P_RST;
  logic [15:0] ki = GAIN_I_RST;
  logic [15:0] kd = GAIN_D_RST;
  logic [9:0]  band = DEAD_BAND_RST;
  longint      integ_acc = 0;
  longint      last_err = 0;
  logic [31:0] last_ms = '0;

  tick_t  tick_q[$];
  drive_t drive_exp_q[$];
  tick_t  on_bus;
  logic   in_fire = 1'b0;
  logic   out_fire = 1'b0;
  logic [31:0] ms_clock = '0;
  int send_wait = 0;
  int recv_wait = 0;
  int send_idle_max = 9;
  int recv_idle_max = 9;
  int quiet = 0;
  int n_bad = 0;

  steering_pid_drive_control dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predict the drive output of one control tick and advance the loop state
  function automatic drive_t compute_drive(input tick_t t);
    drive_t      r;
    logic [31:0] dt;
    longint      tgt, e, integ, p, i, d, s, mag, abs_e, rep;
    logic        run, is_auto;
    r.duty = '0;
    r.side = SIDE_OFF;
    r.status = ST_N;
    r.pot_echo = t.pot;
    run = 1'b0;
    is_auto = 1'b0;
    tgt = 0;
    if (!t.link) begin
      r.status = ST_NOSIG;
    end else if (t.mode == MODE_PAUSE) begin
      r.status = ST_PAUSE;
    end else if (t.mode == MODE_MANUAL) begin
      run = 1'b1;
      tgt = t.man_tgt;
    end else if (t.mode == MODE_AUTO) begin
      if (t.fresh) begin
        run = 1'b1;
        is_auto = 1'b1;
        tgt = t.auto_tgt;
      end else begin
        r.status = ST_HOLD;
      end
    end else begin
      r.status = ST_ERROR;
    end

    if (run) begin
      dt = t.now_ms - last_ms;
      e = tgt - longint'(t.pot);
      if (e < ERR_LO) e = ERR_LO;
      if (e > ERR_HI) e = ERR_HI;
      integ = integ_acc + e * longint'(dt);
      if (integ > INTEG_LIM) integ = INTEG_LIM;
      if (integ < -INTEG_LIM) integ = -INTEG_LIM;
      p = longint'(kp) * e;
      i = longint'(ki) * integ / MS_PER_S;
      // no derivative on a zero time step
      d = 0;
      if (dt != 0) d = longint'(kd) * (e - last_err) * MS_PER_S / longint'(dt);
      s = p + i + d;
      last_ms = t.now_ms;
      last_err = e;
      integ_acc = integ;

      abs_e = (e < 0) ? -e : e;
      if (abs_e <= longint'(band)) begin
        r.status = is_auto ? ST_AN : ST_N;
      end else begin
        mag = ((s < 0) ? -s : s) / Q8_ONE;
        if (mag > longint'(DUTY_MAX)) mag = longint'(DUTY_MAX);
        r.duty = mag[7:0];
        if (s > 0) begin
          r.side = SIDE_RIGHT;
          r.status = is_auto ? ST_AR : ST_R;
        end else begin
          r.side = SIDE_LEFT;
          r.status = is_auto ? ST_AL : ST_L;
        end
      end
    end

    rep = last_err;
    if (rep < REP_LO) rep = REP_LO;
    if (rep > REP_HI) rep = REP_HI;
    r.err_rep = rep[9:0];
    return r;
  endfunction

  function automatic void push_tick(input logic [9:0] pot, input logic link,
                                    input logic [7:0] mode, input int man, input int aut,
                                    input logic fresh, input logic [31:0] now);
    tick_t t;
    t.pot = pot;
    t.link = link;
    t.mode = mode;
    t.man_tgt = 12'(man);
    t.auto_tgt = 12'(aut);
    t.fresh = fresh;
    t.now_ms = now;
    tick_q.push_back(t);
  endfunction

  // Mostly a setpoint near the pot, sometimes anywhere in range
  function automatic logic signed [11:0] pick_target(input logic [9:0] pot);
    int v;
    case ($urandom_range(0, 3))
      0:       v = int'($urandom_range(0, 4095)) - 2048;
      1:       v = int'(pot) + int'($urandom_range(0, 80)) - 40;
      default: v = int'(pot) + int'($urandom_range(0, 600)) - 300;
    endcase
    return 12'(v);
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int    sel;
    t.pot = 10'($urandom_range(0, 1023));
    t.link = ($urandom_range(0, 19) != 0);
    sel = $urandom_range(0, 19);
    if (sel < 9) t.mode = MODE_MANUAL;
    else if (sel < 17) t.mode = MODE_AUTO;
    else if (sel == 17) t.mode = MODE_PAUSE;
    else t.mode = 8'($urandom);
    t.fresh = ($urandom_range(0, 9) != 0);
    t.man_tgt = pick_target(t.pot);
    t.auto_tgt = pick_target(t.pot);
    // advance the clock, now and then stand still or jump anywhere
    sel = $urandom_range(0, 19);
    if (sel == 0) ms_clock = $urandom;
    else if (sel > 2) ms_clock = ms_clock + $urandom_range(1, 200);
    t.now_ms = ms_clock;
    return t;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_GAIN_P:    kp = val;
      CFG_GAIN_I:    ki = val;
      CFG_GAIN_D:    kd = val;
      CFG_DEAD_BAND: band = val[9:0];
      default:       ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_gains(input logic [15:0] p, input logic [15:0] i,
                             input logic [15:0] d, input logic [9:0] db);
    write_reg(CFG_GAIN_P, p);
    write_reg(CFG_GAIN_I, i);
    write_reg(CFG_GAIN_D, d);
    write_reg(CFG_DEAD_BAND, {6'd0, db});
  endtask

  // Hold the sender until every expected result is back, then let the block settle
  task automatic drain();
    while (tick_q.size() != 0 || in_valid || drive_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Present queued ticks with a random gap before each transfer
  always @(negedge clk) begin : tick_driver
    logic vld;
    vld = in_valid;
    if (rst_n && (!in_valid || in_fire)) begin
      vld = 1'b0;
      if (send_wait > 0) begin
        send_wait--;
      end else if (tick_q.size() != 0) begin
        on_bus = tick_q.pop_front();
        in_pot_reading <= on_bus.pot;
        in_link_good <= on_bus.link;
        in_drive_mode <= on_bus.mode;
        in_manual_target <= on_bus.man_tgt;
        in_auto_target <= on_bus.auto_tgt;
        in_command_fresh <= on_bus.fresh;
        in_now_ms <= on_bus.now_ms;
        vld = 1'b1;
        send_wait = $urandom_range(0, send_idle_max);
      end
    end
    in_valid <= vld;
  end

  // Record the expected result of each accepted tick
  always @(posedge clk) begin : tick_capture
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) drive_exp_q.push_back(compute_drive(on_bus));
  end

  // Stall each result for a random number of cycles
  always @(negedge clk) begin : drive_receiver
    if (out_fire) recv_wait = $urandom_range(0, recv_idle_max);
    if (out_valid === 1'b1 && recv_wait > 0) begin
      recv_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_idle_max != 0) && (out_valid !== 1'b1) &&
                   ($urandom_range(0, 3) == 0);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : drive_monitor
    drive_t want;
    out_fire = rst_n && (out_valid === 1'b1) && !out_stall;
    if (out_fire) begin
      if (drive_exp_q.size() == 0) begin
        $error("result transfer with nothing expected");
        n_bad++;
      end else begin
        want = drive_exp_q.pop_front();
        if (out_pwm_duty !== want.duty) begin
          $error("pwm_duty: expected %0d, got %0d", want.duty, out_pwm_duty);
          n_bad++;
        end
        if (out_drive_side !== want.side) begin
          $error("drive_side: expected %0d, got %0d", want.side, out_drive_side);
          n_bad++;
        end
        if (out_status_code !== want.status) begin
          $error("status_code: expected %0d, got %0d", want.status, out_status_code);
          n_bad++;
        end
        if (out_pot_echo !== want.pot_echo) begin
          $error("pot_echo: expected %0d, got %0d", want.pot_echo, out_pot_echo);
          n_bad++;
        end
        if (out_error_report !== want.err_rep) begin
          $error("error_report: expected %0d, got %0d", want.err_rep, out_error_report);
          n_bad++;
        end
      end
    end
  end

  // End the run when nothing has moved for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] p, i, d;
    logic [9:0]  db;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Stop cases, then the PID at reset gains: deadband, saturation, both sides, wrap
    push_tick(10'd300, 1'b0, MODE_MANUAL, 900, 0, 1'b1, 32'd5);
    push_tick(10'd300, 1'b1, MODE_PAUSE, 900, 0, 1'b1, 32'd6);
    push_tick(10'd300, 1'b1, MODE_AUTO, 0, 900, 1'b0, 32'd7);
    push_tick(10'd300, 1'b1, MODE_UNKNOWN_LO, 900, 900, 1'b1, 32'd8);
    push_tick(10'd300, 1'b1, MODE_UNKNOWN_HI, 900, 900, 1'b1, 32'd9);
    push_tick(10'd0, 1'b1, MODE_MANUAL, 5, 0, 1'b1, 32'd0);
    push_tick(10'd0, 1'b1, MODE_MANUAL, 2047, -2048, 1'b1, 32'd100);
    push_tick(10'd1023, 1'b1, MODE_MANUAL, -2048, 2047, 1'b1, 32'd150);
    push_tick(10'd1023, 1'b1, MODE_PAUSE, 0, 0, 1'b0, 32'd160);
    push_tick(10'd500, 1'b1, MODE_AUTO, 0, 500, 1'b1, 32'd200);
    push_tick(10'd500, 1'b1, MODE_AUTO, 0, 600, 1'b1, 32'd250);
    push_tick(10'd500, 1'b1, MODE_AUTO, 0, 400, 1'b1, 32'd250);
    push_tick(10'd500, 1'b1, MODE_MANUAL, 511, 0, 1'b1, 32'hFFFF_FFF0);
    push_tick(10'd500, 1'b1, MODE_MANUAL, 489, 0, 1'b1, 32'h0000_0010);
    push_tick(10'd500, 1'b0, MODE_MANUAL, 489, 0, 1'b1, 32'h0000_0018);
    drain();

    // Zero gains: a zero sum outside the deadband drives left at zero duty
    apply_gains(16'd0, 16'd0, 16'd0, 10'd0);
    push_tick(10'd200, 1'b1, MODE_MANUAL, 201, 0, 1'b1, 32'h0000_0020);
    push_tick(10'd200, 1'b1, MODE_AUTO, 0, 199, 1'b1, 32'h0000_0030);
    push_tick(10'd200, 1'b1, MODE_MANUAL, 200, 0, 1'b1, 32'h0000_0040);
    drain();

    // Full gains, widest deadband: integral clamps both ways, zero step with full error
    apply_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1023);
    push_tick(10'd0, 1'b1, MODE_MANUAL, 2047, 0, 1'b1, 32'd100_064);
    push_tick(10'd1023, 1'b1, MODE_MANUAL, -2048, 0, 1'b1, 32'd200_064);
    push_tick(10'd0, 1'b1, MODE_MANUAL, 1000, 0, 1'b1, 32'd200_100);
    push_tick(10'd1023, 1'b1, MODE_AUTO, 0, -2048, 1'b1, 32'd200_100);
    drain();
    ms_clock = 32'd200_100;

    // Random phases, each with its own gains and idle pattern
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          p = 16'hFFFF; i = 16'hFFFF; d = 16'hFFFF; db = 10'd0;
        end
        1: begin
          p = 16'd0; i = 16'd0; d = 16'd0; db = 10'd1023;
        end
        6: begin
          p = 16'($urandom); i = 16'($urandom); d = 16'($urandom);
          db = 10'($urandom);
        end
        default: begin
          p = 16'($urandom_range(0, 2048));
          i = 16'($urandom_range(0, 1024));
          d = 16'($urandom_range(0, 512));
          db = 10'($urandom_range(0, 40));
        end
      endcase
      apply_gains(p, i, d, db);
      send_idle_max = (ph % 3 == 0) ? 0 : 9;
      recv_idle_max = (ph % 2 == 0) ? 9 : 0;
      repeat (PHASE_TICKS) tick_q.push_back(rand_tick());
      drain();
    end

    if (n_bad == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
